[src/nca_pkg.sv]
// Shared types, widths and constants for the nearest-centroid classifier.
// Used by nca_rdiv, nca_square and nearest_centroid_assign; no dependencies.

package nca_pkg;

  // Cluster table size and per-cluster member limit
  localparam int CLUSTERS   = 16;
  localparam int LABEL_W    = 4;
  localparam int MAX_POINTS = 4096;
  localparam int CNT_W      = $clog2(MAX_POINTS) + 1;

  // Coordinates are signed Q8.8
  localparam int COORD_W = 16;
  localparam int SUM_W   = COORD_W + $clog2(MAX_POINTS) + 1;

  // Rounding divider: numerator 2*|sum| + count, denominator 2*count
  localparam int QUO_W  = COORD_W;
  localparam int NUM_W  = SUM_W + 1;
  localparam int DEN_W  = CNT_W + 1;
  localparam int STEP_W = $clog2(QUO_W);

  // Squared distance: each term fits 2*COORD_W bits, the sum one more
  localparam int SQ_W   = 2 * COORD_W;
  localparam int DIST_W = SQ_W + 1;

  localparam int STATUS_W = 1;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_ADD      = 2'd1,
    OP_CLASSIFY = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 1'b0,
    STAT_EMPTY = 1'b1
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FSCAN,
    ST_FDIVX,
    ST_FDIVY,
    ST_SQX,
    ST_SQY,
    ST_CMP,
    ST_DONE
  } state_t;

endpackage

[src/nearest_centroid_assign.sv]
// Nearest-centroid classifier top level: cluster sums, sequencer, result register.
// Depends on nca_pkg, nca_rdiv and nca_square.
//
//   channel | ports                              | direction
//   --------+------------------------------------+----------
//   in      | in_valid/in_ready, op, label, x, y | in
//   out     | out_valid/out_ready, cluster, status | out
//
// The first classify after a change to the members first scans each cluster and
// runs one pass per nonempty cluster and axis on the single shared rounding
// divider. Distance uses one shared squaring unit. in_ready is low while a
// classify is in progress; it holds in the final state until the previous
// result is taken. Reset is sync.

module nearest_centroid_assign (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_op,
  input  logic [nca_pkg::LABEL_W-1:0]        in_label,
  input  logic signed [nca_pkg::COORD_W-1:0] in_x,
  input  logic signed [nca_pkg::COORD_W-1:0] in_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [nca_pkg::LABEL_W-1:0]        out_cluster,
  output logic [nca_pkg::STATUS_W-1:0]       out_status
);

  nca_pkg::state_t state_r, state_nxt;

  // Cluster store
  logic signed [nca_pkg::SUM_W-1:0]   sum_x_r [nca_pkg::CLUSTERS];
  logic signed [nca_pkg::SUM_W-1:0]   sum_y_r [nca_pkg::CLUSTERS];
  logic        [nca_pkg::CNT_W-1:0]   cnt_r   [nca_pkg::CLUSTERS];
  logic signed [nca_pkg::COORD_W-1:0] cx_r    [nca_pkg::CLUSTERS];
  logic signed [nca_pkg::COORD_W-1:0] cy_r    [nca_pkg::CLUSTERS];
  logic                               fresh_r;
  logic                               any_r;

  // Query and search registers
  logic signed [nca_pkg::COORD_W-1:0] px_r;
  logic signed [nca_pkg::COORD_W-1:0] py_r;
  logic        [nca_pkg::LABEL_W-1:0] idx_r;
  logic        [nca_pkg::SQ_W-1:0]    dx2_r;
  logic                               found_r;
  logic        [nca_pkg::LABEL_W-1:0] best_r;
  logic        [nca_pkg::DIST_W-1:0]  best_dist_r;

  // Result register
  logic                               out_valid_r;
  logic        [nca_pkg::LABEL_W-1:0] out_cluster_r;
  logic        [nca_pkg::STATUS_W-1:0] out_status_r;

  // Combinational control
  nca_pkg::op_t                       op;
  logic                               accept;
  logic        [nca_pkg::LABEL_W-1:0] rd_idx;
  logic signed [nca_pkg::SUM_W-1:0]   rd_sum_x;
  logic signed [nca_pkg::SUM_W-1:0]   rd_sum_y;
  logic        [nca_pkg::CNT_W-1:0]   rd_cnt;
  logic signed [nca_pkg::COORD_W-1:0] rd_cx;
  logic signed [nca_pkg::COORD_W-1:0] rd_cy;
  logic                               nonempty;
  logic                               last;
  logic        [nca_pkg::LABEL_W-1:0] idx_next;
  logic                               out_free;

  logic                               div_start;
  logic signed [nca_pkg::SUM_W-1:0]   div_sum;
  logic                               div_done;
  logic        [nca_pkg::COORD_W-1:0] div_quo;
  logic                               wr_cx;
  logic                               wr_cy;
  logic                               idx_clr;
  logic                               idx_adv;
  logic                               sq_en;
  logic signed [nca_pkg::COORD_W-1:0] sq_a;
  logic signed [nca_pkg::COORD_W-1:0] sq_b;
  logic        [nca_pkg::SQ_W-1:0]    sq;
  logic        [nca_pkg::DIST_W-1:0]  cur_dist;
  logic                               better;
  logic                               form_end;
  logic                               load_out;
  logic signed [nca_pkg::SUM_W-1:0]   add_x;
  logic signed [nca_pkg::SUM_W-1:0]   add_y;

  assign op       = nca_pkg::op_t'(in_op);
  assign in_ready = (state_r == nca_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Single read port into the cluster store
  assign rd_idx   = (state_r == nca_pkg::ST_IDLE) ? in_label : idx_r;
  assign rd_sum_x = sum_x_r[rd_idx];
  assign rd_sum_y = sum_y_r[rd_idx];
  assign rd_cnt   = cnt_r[rd_idx];
  assign rd_cx    = cx_r[rd_idx];
  assign rd_cy    = cy_r[rd_idx];
  assign nonempty = (rd_cnt != '0);
  assign last     = (idx_r == nca_pkg::LABEL_W'(nca_pkg::CLUSTERS - 1));
  assign idx_next = last ? '0 : (idx_r + nca_pkg::LABEL_W'(1));

  // Sign-extend the point for accumulation
  assign add_x = {{(nca_pkg::SUM_W - nca_pkg::COORD_W){in_x[nca_pkg::COORD_W-1]}}, in_x};
  assign add_y = {{(nca_pkg::SUM_W - nca_pkg::COORD_W){in_y[nca_pkg::COORD_W-1]}}, in_y};

  // Distance of the current cluster and comparison with the best so far
  assign cur_dist = nca_pkg::DIST_W'(dx2_r) + nca_pkg::DIST_W'(sq);
  assign better   = !found_r || (cur_dist < best_dist_r);

  nca_rdiv u_rdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .sum   (div_sum),
    .count (rd_cnt),
    .done  (div_done),
    .quo   (div_quo)
  );

  nca_square u_square (
    .clk (clk),
    .en  (sq_en),
    .a   (sq_a),
    .b   (sq_b),
    .sq  (sq)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nca_pkg::ST_IDLE: begin
        if (accept && (op == nca_pkg::OP_CLASSIFY)) begin
          state_nxt = fresh_r ? nca_pkg::ST_SQX : nca_pkg::ST_FSCAN;
        end
      end
      nca_pkg::ST_FSCAN: begin
        if (nonempty) begin
          state_nxt = nca_pkg::ST_FDIVX;
        end else if (last) begin
          state_nxt = nca_pkg::ST_SQX;
        end
      end
      nca_pkg::ST_FDIVX: begin
        if (div_done) begin
          state_nxt = nca_pkg::ST_FDIVY;
        end
      end
      nca_pkg::ST_FDIVY: begin
        if (div_done) begin
          state_nxt = last ? nca_pkg::ST_SQX : nca_pkg::ST_FSCAN;
        end
      end
      nca_pkg::ST_SQX: begin
        if (nonempty) begin
          state_nxt = nca_pkg::ST_SQY;
        end else if (last) begin
          state_nxt = nca_pkg::ST_DONE;
        end
      end
      nca_pkg::ST_SQY: begin
        state_nxt = nca_pkg::ST_CMP;
      end
      nca_pkg::ST_CMP: begin
        state_nxt = last ? nca_pkg::ST_DONE : nca_pkg::ST_SQX;
      end
      nca_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = nca_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = nca_pkg::ST_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    div_start = 1'b0;
    div_sum   = rd_sum_x;
    wr_cx     = 1'b0;
    wr_cy     = 1'b0;
    idx_clr   = 1'b0;
    idx_adv   = 1'b0;
    sq_en     = 1'b0;
    sq_a      = px_r;
    sq_b      = rd_cx;
    form_end  = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      nca_pkg::ST_IDLE: begin
        idx_clr = accept;
      end
      nca_pkg::ST_FSCAN: begin
        div_start = nonempty;
        idx_adv   = !nonempty;
        form_end  = !nonempty && last;
      end
      nca_pkg::ST_FDIVX: begin
        wr_cx     = div_done;
        div_start = div_done;
        div_sum   = rd_sum_y;
      end
      nca_pkg::ST_FDIVY: begin
        wr_cy    = div_done;
        idx_adv  = div_done;
        form_end = div_done && last;
      end
      nca_pkg::ST_SQX: begin
        sq_en   = nonempty;
        idx_adv = !nonempty;
      end
      nca_pkg::ST_SQY: begin
        sq_en = 1'b1;
        sq_a  = py_r;
        sq_b  = rd_cy;
      end
      nca_pkg::ST_CMP: begin
        idx_adv = 1'b1;
      end
      nca_pkg::ST_DONE: begin
        load_out = out_free;
      end
      default: begin
        idx_clr = 1'b0;
      end
    endcase
  end

  // State register and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nca_pkg::ST_IDLE;
      fresh_r <= 1'b0;
      any_r   <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && ((op == nca_pkg::OP_CLEAR) ||
                     ((op == nca_pkg::OP_ADD) &&
                      (rd_cnt < nca_pkg::CNT_W'(nca_pkg::MAX_POINTS))))) begin
        fresh_r <= 1'b0;
      end else if (form_end) begin
        fresh_r <= any_r || wr_cy;
      end
      if (idx_clr) begin
        any_r   <= 1'b0;
        found_r <= 1'b0;
      end else begin
        if (wr_cy) begin
          any_r <= 1'b1;
        end
        if ((state_r == nca_pkg::ST_CMP) && better) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  // Cluster sums and counts: clear, or accumulate one member point while the cluster holds fewer than MAX_POINTS
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < nca_pkg::CLUSTERS; i++) begin
        sum_x_r[i] <= '0;
        sum_y_r[i] <= '0;
        cnt_r[i]   <= '0;
      end
    end else if (accept && (op == nca_pkg::OP_CLEAR)) begin
      for (int i = 0; i < nca_pkg::CLUSTERS; i++) begin
        sum_x_r[i] <= '0;
        sum_y_r[i] <= '0;
        cnt_r[i]   <= '0;
      end
    end else if (accept && (op == nca_pkg::OP_ADD) &&
                 (rd_cnt < nca_pkg::CNT_W'(nca_pkg::MAX_POINTS))) begin
      sum_x_r[in_label] <= rd_sum_x + add_x;
      sum_y_r[in_label] <= rd_sum_y + add_y;
      cnt_r[in_label]   <= rd_cnt + nca_pkg::CNT_W'(1);
    end
  end

  // Centroid store, written from the divider
  always_ff @(posedge clk) begin
    if (wr_cx) begin
      cx_r[idx_r] <= div_quo;
    end
    if (wr_cy) begin
      cy_r[idx_r] <= div_quo;
    end
  end

  // Query point, scan index and best-so-far tracking
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= in_x;
      py_r <= in_y;
    end
    if (idx_clr) begin
      idx_r <= '0;
    end else if (idx_adv) begin
      idx_r <= idx_next;
    end
    if (state_r == nca_pkg::ST_SQY) begin
      dx2_r <= sq;
    end
    if ((state_r == nca_pkg::ST_CMP) && better) begin
      best_r      <= idx_r;
      best_dist_r <= cur_dist;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_cluster_r <= found_r ? best_r : '0;
      out_status_r  <= found_r ? nca_pkg::STAT_OK : nca_pkg::STAT_EMPTY;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_cluster = out_cluster_r;
  assign out_status  = out_status_r;

endmodule

[src/nca_rdiv.sv]
// Iterative restoring divider: signed sum / count, rounded to nearest,
// halves away from zero. One quotient bit per cycle. Depends on nca_pkg.

module nca_rdiv (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [nca_pkg::SUM_W-1:0] sum,
  input  logic        [nca_pkg::CNT_W-1:0] count,
  output logic                             done,
  output logic        [nca_pkg::COORD_W-1:0] quo
);

  logic                         busy_r;
  logic                         done_r;
  logic [nca_pkg::STEP_W-1:0]   step_r;
  logic                         neg_r;
  logic [nca_pkg::DEN_W-1:0]    rem_r;
  logic [nca_pkg::QUO_W-1:0]    num_r;
  logic [nca_pkg::DEN_W-1:0]    den_r;

  logic                         neg;
  logic [nca_pkg::SUM_W-1:0]    mag;
  logic [nca_pkg::NUM_W-1:0]    numer;
  logic [nca_pkg::DEN_W:0]      trial;
  logic [nca_pkg::DEN_W:0]      trial_sub;
  logic                         ge;

  // Form the rounding numerator from the magnitude of the sum
  always_comb begin
    neg   = sum[nca_pkg::SUM_W-1];
    mag   = neg ? (~sum + nca_pkg::SUM_W'(1)) : sum;
    numer = {mag, 1'b0} + nca_pkg::NUM_W'(count);
  end

  // One restoring step: shift in the next numerator bit, subtract if it fits
  always_comb begin
    trial     = {rem_r, num_r[nca_pkg::QUO_W-1]};
    trial_sub = trial - {1'b0, den_r};
    ge        = (trial >= {1'b0, den_r});
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + nca_pkg::STEP_W'(1);
        if (step_r == nca_pkg::STEP_W'(nca_pkg::QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= neg;
      rem_r <= numer[nca_pkg::NUM_W-1:nca_pkg::QUO_W];
      num_r <= numer[nca_pkg::QUO_W-1:0];
      den_r <= {count, 1'b0};
    end else if (busy_r) begin
      rem_r <= ge ? trial_sub[nca_pkg::DEN_W-1:0] : trial[nca_pkg::DEN_W-1:0];
      num_r <= {num_r[nca_pkg::QUO_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? (~num_r + nca_pkg::QUO_W'(1)) : num_r;

endmodule

[src/nca_square.sv]
// Shared squaring unit: registers (a - b)^2 for two signed coordinates.
// Depends on nca_pkg.

module nca_square (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [nca_pkg::COORD_W-1:0] a,
  input  logic signed [nca_pkg::COORD_W-1:0] b,
  output logic        [nca_pkg::SQ_W-1:0]    sq
);

  logic [nca_pkg::COORD_W:0]   diff;
  logic [nca_pkg::COORD_W:0]   diff_abs;
  logic [nca_pkg::COORD_W-1:0] mag;
  logic [nca_pkg::SQ_W-1:0]    sq_r;

  // Absolute difference fits COORD_W unsigned bits
  always_comb begin
    diff     = {a[nca_pkg::COORD_W-1], a} - {b[nca_pkg::COORD_W-1], b};
    diff_abs = diff[nca_pkg::COORD_W] ? (~diff + (nca_pkg::COORD_W+1)'(1)) : diff;
    mag      = diff_abs[nca_pkg::COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= mag * mag;
    end
  end

  assign sq = sq_r;

endmodule
